>>> hdl/linear_probe_hash_table_defines.svh
// Assertion macros used by the hash table checker.
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define LPHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hash table check failed");

// Next-cycle implication, disabled while reset is low.
`define LPHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hash table check failed");

`endif

>>> hdl/lpht_pkg.sv
// Types, constants and codes for the linear probing hash table.
`default_nettype none
package lpht_pkg;

  localparam int SLOTS      = 1024;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;

  localparam int IDX_W     = $clog2(SLOTS);
  localparam int SIZE_W    = $clog2(SLOTS + 1);
  localparam int KV_W      = KEY_BITS + VALUE_BITS;
  localparam int CFG_W     = 11;
  localparam int CNT_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int REQ_W     = 2;
  localparam int STAT_W    = 2;
  localparam int TAG_W     = 2;
  localparam int DIV_CNT_W = $clog2(KEY_BITS);

  localparam logic [CFG_W-1:0] TABLE_SIZE_RST = 11'd1024;
  localparam logic [CFG_W-1:0] MAX_ITEMS_RST  = 11'd1024;

  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITEMS  = 1'd1;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_MISS   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BADKEY = 2'd3;

  localparam logic [TAG_W-1:0] TAG_EMPTY    = 2'd0;
  localparam logic [TAG_W-1:0] TAG_OCCUPIED = 2'd1;
  localparam logic [TAG_W-1:0] TAG_DELETED  = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_FETCH,
    S_CHECK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic                start;
    logic [KEY_BITS-1:0] dividend;
    logic [SIZE_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

>>> hdl/lpht_if.sv
// Request and response channel interfaces of the hash table.
`default_nettype none
interface lpht_req_if;
  import lpht_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [REQ_W-1:0]      req_type;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, req_type, key, value, input ready);
  modport sink   (input valid, req_type, key, value, output ready);
endinterface

interface lpht_rsp_if;
  import lpht_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [STAT_W-1:0]     status;
  logic [VALUE_BITS-1:0] found_value;
  logic [CNT_W-1:0]      item_count;
  logic                  is_full;

  modport source (output valid, status, found_value, item_count, is_full, input ready);
  modport sink   (input valid, status, found_value, item_count, is_full, output ready);
endinterface
`default_nettype wire

>>> hdl/lpht_ram.sv
// Generic single write, single read RAM with registered read data.
`default_nettype none
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

>>> hdl/lpht_mod.sv
// Bit-serial restoring remainder unit: key modulo table size, one bit a cycle.
`default_nettype none
module lpht_mod (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lpht_pkg::div_req_t req_i,
  output      lpht_pkg::div_rsp_t rsp_o
);
  import lpht_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [KEY_BITS-1:0]  dvd_q, dvd_d;
  logic [SIZE_W-1:0]    dvs_q, dvs_d;
  logic [SIZE_W-1:0]    rem_q, rem_d;
  logic [SIZE_W:0]      shifted;
  logic [SIZE_W:0]      trial;

  assign shifted = {rem_q, dvd_q[KEY_BITS-1]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(KEY_BITS - 1);
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the top bit drops safely
      rem_d = (shifted >= {1'b0, dvs_q}) ? trial[SIZE_W-1:0] : shifted[SIZE_W-1:0];
      dvd_d = {dvd_q[KEY_BITS-2:0], 1'b0};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q[IDX_W-1:0];

endmodule
`default_nettype wire

>>> hdl/linear_probe_hash_table.sv
// Top level: open-addressing hash table with linear probing.
//
// Requests arrive on req_i (valid/ready): insert, remove or search a key,
// with a value for insert. Each request gives one response on rsp_o with
// status, found value, item count and a full flag.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 table size, 1 item limit); write only while no request is in flight.
// Steps: the remainder unit reduces the key modulo the table size, the
// first slot is read, the tag and key/value RAMs are probed one slot per
// cycle, and the response is loaded into the output register.
// A zero key or an insert into a full table skips the probe and goes
// straight from idle to the done state and the output register.
// One request at a time; req_i.ready is high only between requests.
// After reset the tag RAM is swept to empty, one slot a cycle over all
// SLOTS slots (1024 here), and req_i.ready stays low until that finishes.
// The response waits in its register while rsp_o.ready is low; a new
// request is still taken meanwhile and its result held until the
// register frees up.
`default_nettype none
module linear_probe_hash_table (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  lpht_req_if.sink                           req_i,
  lpht_rsp_if.source                         rsp_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [lpht_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [lpht_pkg::CFG_W-1:0]     cfg_data_i
);
  import lpht_pkg::*;

  state_e state_q, state_d;

  logic [CFG_W-1:0]      table_size_q, max_items_q;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [IDX_W-1:0]      clr_q, clr_d;
  logic [IDX_W-1:0]      pos_q, pos_d, pos_next;
  logic [SIZE_W-1:0]     n_q, n_d, n_inc;
  logic [REQ_W-1:0]      type_q, type_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [STAT_W-1:0]     stat_q, stat_d;
  logic [VALUE_BITS-1:0] found_q, found_d;

  logic                  out_valid_q, out_valid_d;
  logic [STAT_W-1:0]     out_stat_q, out_stat_d;
  logic [VALUE_BITS-1:0] out_found_q, out_found_d;
  logic [CNT_W-1:0]      out_count_q, out_count_d;
  logic                  out_full_q, out_full_d;

  logic [SIZE_W-1:0] eff_size;
  logic              full;
  logic              accept;
  logic              bad_key;
  logic              out_free;

  logic              tag_we;
  logic [IDX_W-1:0]  tag_waddr, rd_addr;
  logic [TAG_W-1:0]  tag_wdata, tag_rd;
  logic              kv_we;
  logic [KV_W-1:0]   kv_rd;

  logic tag_occ, tag_empty, key_hit, last_probe, chk_finish;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // Effective table size: zero counts as one, oversize clamps to SLOTS.
  always_comb begin
    if (table_size_q == '0) begin
      eff_size = SIZE_W'(1);
    end else if (32'(table_size_q) > 32'(SLOTS)) begin
      eff_size = SIZE_W'(SLOTS);
    end else begin
      eff_size = SIZE_W'(table_size_q);
    end
  end

  assign full = (32'(count_q) >= 32'(max_items_q)) || (32'(count_q) >= 32'(eff_size));

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign bad_key     = (req_i.key == '0);
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign n_inc      = n_q + SIZE_W'(1);
  assign pos_next   = ((SIZE_W'(pos_q) + SIZE_W'(1)) == eff_size) ? '0 : pos_q + IDX_W'(1);
  assign tag_occ    = (tag_rd == TAG_OCCUPIED);
  assign tag_empty  = (tag_rd == TAG_EMPTY);
  assign key_hit    = tag_occ && (kv_rd[KV_W-1:VALUE_BITS] == key_q);
  assign last_probe = (n_inc == eff_size);

  always_comb begin
    unique case (type_q)
      REQ_INSERT: chk_finish = !tag_occ || last_probe;
      REQ_REMOVE: chk_finish = tag_empty || last_probe;
      default:    chk_finish = tag_empty || key_hit || last_probe;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == IDX_W'(SLOTS - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (bad_key || (req_i.req_type == REQ_INSERT && full)) begin
            state_d = S_DONE;
          end else begin
            state_d = S_DIV;
          end
        end
      end
      S_DIV:   if (div_rsp.done) state_d = S_FETCH;
      S_FETCH: state_d = S_CHECK;
      S_CHECK: if (chk_finish) state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    clr_d       = clr_q;
    pos_d       = pos_q;
    n_d         = n_q;
    type_d      = type_q;
    key_d       = key_q;
    val_d       = val_q;
    stat_d      = stat_q;
    found_d     = found_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_stat_d  = out_stat_q;
    out_found_d = out_found_q;
    out_count_d = out_count_q;
    out_full_d  = out_full_q;
    tag_we      = 1'b0;
    tag_waddr   = pos_q;
    tag_wdata   = TAG_OCCUPIED;
    kv_we       = 1'b0;
    rd_addr     = pos_q;
    div_req.start    = 1'b0;
    div_req.dividend = req_i.key;
    div_req.divisor  = eff_size;

    unique case (state_q)
      S_CLEAR: begin
        tag_we    = 1'b1;
        tag_waddr = clr_q;
        tag_wdata = TAG_EMPTY;
        clr_d     = clr_q + IDX_W'(1);
      end
      S_IDLE: begin
        if (accept) begin
          type_d  = req_i.req_type;
          key_d   = req_i.key;
          val_d   = req_i.value;
          found_d = '0;
          n_d     = '0;
          if (bad_key) begin
            stat_d = STAT_BADKEY;
          end else if (req_i.req_type == REQ_INSERT && full) begin
            stat_d = STAT_FULL;
          end else begin
            stat_d        = STAT_MISS;
            div_req.start = 1'b1;
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) pos_d = div_rsp.rem;
      end
      S_FETCH: begin
        rd_addr = pos_q;
      end
      S_CHECK: begin
        // next slot is read ahead; unused once the probe finishes
        rd_addr = pos_next;
        pos_d   = pos_next;
        n_d     = n_inc;
        unique case (type_q)
          REQ_INSERT: begin
            if (!tag_occ) begin
              tag_we  = 1'b1;
              kv_we   = 1'b1;
              count_d = count_q + CNT_W'(1);
              stat_d  = STAT_OK;
            end else if (last_probe) begin
              stat_d = STAT_FULL;
            end
          end
          REQ_REMOVE: begin
            if (key_hit) begin
              tag_we    = 1'b1;
              tag_wdata = TAG_DELETED;
              if (count_q != '0) count_d = count_q - CNT_W'(1);
              stat_d = STAT_OK;
            end
          end
          default: begin
            if (key_hit) begin
              stat_d  = STAT_OK;
              found_d = kv_rd[VALUE_BITS-1:0];
            end
          end
        endcase
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_stat_d  = stat_q;
          out_found_d = found_q;
          out_count_d = count_q;
          out_full_d  = full;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      table_size_q <= TABLE_SIZE_RST;
      max_items_q  <= MAX_ITEMS_RST;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TABLE_SIZE: table_size_q <= cfg_data_i;
          CFG_MAX_ITEMS:  max_items_q  <= cfg_data_i;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    n_q         <= n_d;
    type_q      <= type_d;
    key_q       <= key_d;
    val_q       <= val_d;
    stat_q      <= stat_d;
    found_q     <= found_d;
    out_stat_q  <= out_stat_d;
    out_found_q <= out_found_d;
    out_count_q <= out_count_d;
    out_full_q  <= out_full_d;
  end

  lpht_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  lpht_ram #(
    .WIDTH (TAG_W),
    .DEPTH (SLOTS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (tag_wdata),
    .raddr_i (rd_addr),
    .rdata_o (tag_rd)
  );

  lpht_ram #(
    .WIDTH (KV_W),
    .DEPTH (SLOTS)
  ) u_kv_ram (
    .clk_i   (clk_i),
    .we_i    (kv_we),
    .waddr_i (pos_q),
    .wdata_i ({key_q, val_q}),
    .raddr_i (rd_addr),
    .rdata_o (kv_rd)
  );

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_stat_q;
  assign rsp_o.found_value = out_found_q;
  assign rsp_o.item_count  = out_count_q;
  assign rsp_o.is_full     = out_full_q;

endmodule
`default_nettype wire

>>> hdl/lpht_checker.sv
// Port-level checker for the hash table, bound to the top level.
`default_nettype none
`include "linear_probe_hash_table_defines.svh"
module lpht_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_valid_i,
  input wire logic                            in_ready_i,
  input wire logic                            out_valid_i,
  input wire logic                            out_ready_i,
  input wire logic [lpht_pkg::STAT_W-1:0]     status_i,
  input wire logic [lpht_pkg::VALUE_BITS-1:0] found_value_i,
  input wire logic [lpht_pkg::CNT_W-1:0]      item_count_i
);
  import lpht_pkg::*;

  logic       in_acc, out_acc;
  logic [1:0] pend_q, pend_d;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // requests taken but not yet answered
  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) pend_d = pend_q + 2'd1;
    else if (!in_acc && out_acc) pend_d = pend_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `LPHT_ASSERT_IMP(a_no_orphan_rsp, clk_i, rst_ni, out_valid_i, pend_q != 2'd0)
  `LPHT_ASSERT_IMP(a_pend_bound, clk_i, rst_ni, 1'b1, pend_q != 2'd3)
  `LPHT_ASSERT_IMP(a_found_only_ok, clk_i, rst_ni, out_valid_i && status_i != STAT_OK,
                   found_value_i == '0)
  `LPHT_ASSERT_IMP(a_count_range, clk_i, rst_ni, out_valid_i, 32'(item_count_i) <= 32'(SLOTS))
  `LPHT_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
                   out_valid_i && $stable(status_i) && $stable(found_value_i))

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (req_i.valid),
  .in_ready_i    (req_i.ready),
  .out_valid_i   (rsp_o.valid),
  .out_ready_i   (rsp_o.ready),
  .status_i      (rsp_o.status),
  .found_value_i (rsp_o.found_value),
  .item_count_i  (rsp_o.item_count)
);
`default_nettype wire
